[hdl/mrtu_pkg.sv]
`timescale 1ns / 1ps
// shared types, codes and the crc-16 byte step of the modbus rtu master
package mrtu_pkg;

    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_RESP  = 2'd2;
    localparam logic [1:0] CMD_LINK  = 2'd3;

    localparam logic [2:0] LINK_OK      = 3'd0;
    localparam logic [2:0] LINK_TIMEOUT = 3'd1;
    localparam logic [2:0] LINK_PARAM   = 3'd2;
    localparam logic [2:0] LINK_RETRY   = 3'd3;
    localparam logic [2:0] LINK_BUSY    = 3'd4;

    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_PARAM     = 4'd1;
    localparam logic [3:0] ST_TIMEOUT   = 4'd2;
    localparam logic [3:0] ST_CRC       = 4'd3;
    localparam logic [3:0] ST_SLAVE     = 4'd4;
    localparam logic [3:0] ST_FUNCTION  = 4'd5;
    localparam logic [3:0] ST_EXCEPTION = 4'd6;
    localparam logic [3:0] ST_LENGTH    = 4'd7;
    localparam logic [3:0] ST_BUSY      = 4'd8;

    localparam logic KIND_FRAME  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [7:0]  FUNC_READ   = 8'h03;
    localparam logic [7:0]  FUNC_WRITE  = 8'h06;
    localparam logic [7:0]  FUNC_EXC    = 8'h80;
    localparam logic [15:0] READ_QTY    = 16'h0001;
    localparam logic [7:0]  READ_BCOUNT = 8'h02;
    localparam logic [7:0]  SID_MAX     = 8'd247;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam int          REQ_LEN      = 8;
    localparam int          IDX_W        = 3;
    localparam logic [2:0]  REQ_CRC_POS  = 3'd6;
    localparam logic [2:0]  REQ_LAST_POS = 3'd7;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  slave_address;
        logic [15:0] register_address;
        logic [15:0] write_value;
        logic [7:0]  rx_byte;
        logic        rx_last;
        logic [2:0]  link_status;
    } item_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  tx_byte;
        logic        last;
        logic [3:0]  status;
        logic [15:0] read_value;
        logic [7:0]  exc_code;
    } result_t;

    typedef struct packed {
        logic        is_req;
        logic [7:0]  sid;
        logic [7:0]  func;
        logic [15:0] addr;
        logic [15:0] data;
        logic [3:0]  status;
        logic [15:0] val;
        logic [7:0]  exc;
    } job_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

[hdl/mrtu_queue.sv]
`timescale 1ns / 1ps
// short job queue between the front end and the back end
module mrtu_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  mrtu_pkg::job_t push_job,
    output logic          full,
    input  logic          pop,
    output mrtu_pkg::job_t pop_job,
    output logic          empty
);

    mrtu_pkg::job_t                 slot_reg [mrtu_pkg::Q_DEPTH];
    logic [mrtu_pkg::Q_PTR_W-1:0]   wr_ptr_reg;
    logic [mrtu_pkg::Q_PTR_W-1:0]   rd_ptr_reg;
    logic [mrtu_pkg::Q_CNT_W-1:0]   count_reg;
    logic [mrtu_pkg::Q_CNT_W-1:0]   count_next;

    assign full    = (count_reg == mrtu_pkg::Q_CNT_W'(mrtu_pkg::Q_DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_job = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

    ap_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full || pop)
        else $error("queue push while full");

    ap_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue pop while empty");

    ap_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= mrtu_pkg::Q_CNT_W'(mrtu_pkg::Q_DEPTH))
        else $error("queue count out of range");

endmodule

[hdl/mrtu_front.sv]
`timescale 1ns / 1ps
// front end: accepts transactions, tracks the response and queues jobs
module mrtu_front
#(
    parameter int RX_MAX_LEN = 256
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_valid,
    output logic           item_stall,
    input  mrtu_pkg::item_t item,
    input  logic           q_full,
    output logic           push,
    output mrtu_pkg::job_t push_job
);

    localparam int CNT_W = $clog2(RX_MAX_LEN + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(RX_MAX_LEN);

    logic [7:0]       req_sid_reg,  req_sid_next;
    logic [7:0]       req_func_reg, req_func_next;
    logic [15:0]      req_addr_reg, req_addr_next;
    logic [15:0]      req_data_reg, req_data_next;
    logic [CNT_W-1:0] rx_count_reg, rx_count_next;
    logic [15:0]      rx_crc_reg,   rx_crc_next;
    logic [15:0]      rx_delay_reg, rx_delay_next;
    logic [7:0]       head_reg  [8];
    logic [7:0]       head_next [8];

    logic [CNT_W-1:0] cnt_upd;
    logic [15:0]      crc_upd;
    logic [15:0]      delay_upd;
    logic [7:0]       head_upd [8];
    logic [15:0]      got;
    logic [3:0]       v_status;
    logic [15:0]      v_val;
    logic [7:0]       v_exc;
    logic             accept;

    assign item_stall = q_full;
    assign accept     = item_valid && !q_full;

    // receiver update for one response byte
    always_comb
    begin
        cnt_upd   = rx_count_reg;
        crc_upd   = rx_crc_reg;
        delay_upd = rx_delay_reg;
        head_upd  = head_reg;
        if (rx_count_reg < MAX_CNT)
        begin
            if (rx_count_reg >= CNT_W'(2))
                crc_upd = mrtu_pkg::crc_byte(rx_crc_reg, rx_delay_reg[15:8]);
            delay_upd = {rx_delay_reg[7:0], item.rx_byte};
            if (rx_count_reg < CNT_W'(8))
                head_upd[rx_count_reg[2:0]] = item.rx_byte;
            cnt_upd = rx_count_reg + 1'b1;
        end
    end

    // response check in priority order
    always_comb
    begin
        got      = {delay_upd[7:0], delay_upd[15:8]};
        v_status = mrtu_pkg::ST_OK;
        v_val    = '0;
        v_exc    = '0;
        if (cnt_upd < CNT_W'(4))
            v_status = mrtu_pkg::ST_LENGTH;
        else if (got != crc_upd)
            v_status = mrtu_pkg::ST_CRC;
        else if (head_upd[1][7])
        begin
            if (cnt_upd != CNT_W'(5) || head_upd[1] != (req_func_reg | mrtu_pkg::FUNC_EXC))
                v_status = mrtu_pkg::ST_FUNCTION;
            else if (head_upd[0] != req_sid_reg)
                v_status = mrtu_pkg::ST_SLAVE;
            else
            begin
                v_status = mrtu_pkg::ST_EXCEPTION;
                v_exc    = head_upd[2];
            end
        end
        else if (head_upd[0] != req_sid_reg)
            v_status = mrtu_pkg::ST_SLAVE;
        else if (head_upd[1] != req_func_reg)
            v_status = mrtu_pkg::ST_FUNCTION;
        else if (req_func_reg == mrtu_pkg::FUNC_READ)
        begin
            if (cnt_upd != CNT_W'(7) || head_upd[2] != mrtu_pkg::READ_BCOUNT)
                v_status = mrtu_pkg::ST_LENGTH;
            else
                v_val = {head_upd[3], head_upd[4]};
        end
        else if (req_func_reg == mrtu_pkg::FUNC_WRITE)
        begin
            // crc bytes of the echo follow from a good crc and equal body bytes
            if (cnt_upd != CNT_W'(8))
                v_status = mrtu_pkg::ST_LENGTH;
            else if (head_upd[2] != req_addr_reg[15:8] || head_upd[3] != req_addr_reg[7:0]
                     || head_upd[4] != req_data_reg[15:8] || head_upd[5] != req_data_reg[7:0])
                v_status = mrtu_pkg::ST_FUNCTION;
        end
    end

    always_comb
    begin
        req_sid_next  = req_sid_reg;
        req_func_next = req_func_reg;
        req_addr_next = req_addr_reg;
        req_data_next = req_data_reg;
        rx_count_next = rx_count_reg;
        rx_crc_next   = rx_crc_reg;
        rx_delay_next = rx_delay_reg;
        head_next     = head_reg;
        push          = 1'b0;
        push_job      = '0;
        if (accept)
        begin
            case (item.cmd)
                mrtu_pkg::CMD_READ, mrtu_pkg::CMD_WRITE:
                begin
                    push = 1'b1;
                    if (item.slave_address == 8'd0 || item.slave_address > mrtu_pkg::SID_MAX)
                    begin
                        push_job.is_req = 1'b0;
                        push_job.status = mrtu_pkg::ST_PARAM;
                    end
                    else
                    begin
                        req_sid_next  = item.slave_address;
                        req_func_next = (item.cmd == mrtu_pkg::CMD_READ) ?
                                        mrtu_pkg::FUNC_READ : mrtu_pkg::FUNC_WRITE;
                        req_addr_next = item.register_address;
                        req_data_next = (item.cmd == mrtu_pkg::CMD_READ) ?
                                        mrtu_pkg::READ_QTY : item.write_value;
                        rx_count_next = '0;
                        rx_crc_next   = mrtu_pkg::CRC_INIT;
                        rx_delay_next = '0;
                        push_job.is_req = 1'b1;
                        push_job.sid    = req_sid_next;
                        push_job.func   = req_func_next;
                        push_job.addr   = req_addr_next;
                        push_job.data   = req_data_next;
                    end
                end
                mrtu_pkg::CMD_RESP:
                begin
                    head_next = head_upd;
                    if (item.rx_last)
                    begin
                        push            = 1'b1;
                        push_job.status = v_status;
                        push_job.val    = v_val;
                        push_job.exc    = v_exc;
                        rx_count_next   = '0;
                        rx_crc_next     = mrtu_pkg::CRC_INIT;
                        rx_delay_next   = '0;
                    end
                    else
                    begin
                        rx_count_next = cnt_upd;
                        rx_crc_next   = crc_upd;
                        rx_delay_next = delay_upd;
                    end
                end
                mrtu_pkg::CMD_LINK:
                begin
                    if (item.link_status != mrtu_pkg::LINK_OK)
                    begin
                        push = 1'b1;
                        case (item.link_status)
                            mrtu_pkg::LINK_PARAM: push_job.status = mrtu_pkg::ST_PARAM;
                            mrtu_pkg::LINK_RETRY: push_job.status = mrtu_pkg::ST_LENGTH;
                            mrtu_pkg::LINK_BUSY:  push_job.status = mrtu_pkg::ST_BUSY;
                            default:              push_job.status = mrtu_pkg::ST_TIMEOUT;
                        endcase
                        rx_count_next = '0;
                        rx_crc_next   = mrtu_pkg::CRC_INIT;
                        rx_delay_next = '0;
                    end
                end
                default:
                begin
                    push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_func_reg <= '0;
            rx_count_reg <= '0;
            rx_crc_reg   <= mrtu_pkg::CRC_INIT;
            rx_delay_reg <= '0;
        end
        else
        begin
            req_func_reg <= req_func_next;
            rx_count_reg <= rx_count_next;
            rx_crc_reg   <= rx_crc_next;
            rx_delay_reg <= rx_delay_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_sid_reg  <= req_sid_next;
        req_addr_reg <= req_addr_next;
        req_data_reg <= req_data_next;
        head_reg     <= head_next;
    end

endmodule

[hdl/mrtu_back.sv]
`timescale 1ns / 1ps
// back end: serial crc frame builder and result register
module mrtu_back
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_empty,
    output logic             pop,
    input  mrtu_pkg::job_t   pop_job,
    output logic             result_valid,
    input  logic             result_stall,
    output mrtu_pkg::result_t result
);

    logic                         busy_reg, busy_next;
    logic [mrtu_pkg::IDX_W-1:0]   idx_reg,  idx_next;
    logic [15:0]                  crc_reg,  crc_next;
    mrtu_pkg::job_t               hold_reg, hold_next;
    logic                         result_valid_reg, result_valid_next;
    mrtu_pkg::result_t            result_reg, result_next;
    logic                         adv;
    logic [7:0]                   cur_byte;

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        case (idx_reg)
            3'd0:    cur_byte = hold_reg.sid;
            3'd1:    cur_byte = hold_reg.func;
            3'd2:    cur_byte = hold_reg.addr[15:8];
            3'd3:    cur_byte = hold_reg.addr[7:0];
            3'd4:    cur_byte = hold_reg.data[15:8];
            3'd5:    cur_byte = hold_reg.data[7:0];
            3'd6:    cur_byte = crc_reg[7:0];
            3'd7:    cur_byte = crc_reg[15:8];
            default: cur_byte = 8'h00;
        endcase
    end

    always_comb
    begin
        adv               = !result_valid_reg || !result_stall;
        pop               = adv && !busy_reg && !q_empty;
        busy_next         = busy_reg;
        idx_next          = idx_reg;
        crc_next          = crc_reg;
        hold_next         = hold_reg;
        result_valid_next = result_valid_reg;
        result_next       = result_reg;
        if (adv)
        begin
            result_valid_next = 1'b0;
            if (busy_reg)
            begin
                result_valid_next   = 1'b1;
                result_next         = '0;
                result_next.kind    = mrtu_pkg::KIND_FRAME;
                result_next.tx_byte = cur_byte;
                result_next.last    = (idx_reg == mrtu_pkg::REQ_LAST_POS);
                result_next.status  = mrtu_pkg::ST_OK;
                if (idx_reg < mrtu_pkg::REQ_CRC_POS)
                    crc_next = mrtu_pkg::crc_byte(crc_reg, cur_byte);
                idx_next = idx_reg + 1'b1;
                if (idx_reg == mrtu_pkg::REQ_LAST_POS)
                    busy_next = 1'b0;
            end
            else if (!q_empty)
            begin
                result_valid_next = 1'b1;
                result_next       = '0;
                if (pop_job.is_req)
                begin
                    hold_next           = pop_job;
                    busy_next           = 1'b1;
                    idx_next            = mrtu_pkg::IDX_W'(1);
                    crc_next            = mrtu_pkg::crc_byte(mrtu_pkg::CRC_INIT, pop_job.sid);
                    result_next.kind    = mrtu_pkg::KIND_FRAME;
                    result_next.tx_byte = pop_job.sid;
                    result_next.last    = 1'b0;
                    result_next.status  = mrtu_pkg::ST_OK;
                end
                else
                begin
                    result_next.kind       = mrtu_pkg::KIND_STATUS;
                    result_next.last       = 1'b1;
                    result_next.status     = pop_job.status;
                    result_next.read_value = pop_job.val;
                    result_next.exc_code   = pop_job.exc;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg         <= 1'b0;
            idx_reg          <= '0;
            crc_reg          <= mrtu_pkg::CRC_INIT;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg         <= busy_next;
            idx_reg          <= idx_next;
            crc_reg          <= crc_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg   <= hold_next;
        result_reg <= result_next;
    end

    ap_frame_status_ok: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && result_reg.kind == mrtu_pkg::KIND_FRAME
        |-> result_reg.status == mrtu_pkg::ST_OK)
        else $error("frame byte carries a status");

    ap_busy_idx: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> idx_reg != '0)
        else $error("busy with first frame byte not yet sent");

    ap_frame_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy_reg) |-> result_valid_reg && result_reg.kind == mrtu_pkg::KIND_FRAME
                            && !result_reg.last)
        else $error("frame started without its first byte");

endmodule

[hdl/modbus_rtu_master_transaction_top.sv]
`timescale 1ns / 1ps
// top level of the modbus rtu master transaction block
// A read or write request with a valid slave id comes out as eight frame bytes, one per cycle
// while the result port is not stalled; the back end runs the CRC-16 one byte per cycle as the
// bytes go out. Response bytes and link events are taken one per cycle while the queue is not
// full, the response CRC and checks run in the front end, and each status is a single result. A
// four-entry job queue sits between front and back, so input keeps flowing while a frame is
// being sent or a result is stalled; the input stalls only when that queue is full. Results
// leave through a registered output stage. No clearing pass after reset.
module modbus_rtu_master_transaction_top
#(
    parameter int RX_MAX_LEN = 256
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  mrtu_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output mrtu_pkg::result_t result
);

    logic           q_push;
    logic           q_full;
    logic           q_pop;
    logic           q_empty;
    mrtu_pkg::job_t q_in_job;
    mrtu_pkg::job_t q_out_job;

    mrtu_front #(
        .RX_MAX_LEN (RX_MAX_LEN)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .q_full     (q_full),
        .push       (q_push),
        .push_job   (q_in_job)
    );

    mrtu_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (q_in_job),
        .full     (q_full),
        .pop      (q_pop),
        .pop_job  (q_out_job),
        .empty    (q_empty)
    );

    mrtu_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .pop          (q_pop),
        .pop_job      (q_out_job),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// self-checking testbench of the modbus rtu master: request frames, response checks, link events
module testbench;

    localparam int RX_LIMIT       = 256;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int SETTLE_CYCLES  = 60;

    typedef enum int {
        REPLY_GOOD,
        REPLY_CRC,
        REPLY_SID,
        REPLY_FUNC,
        REPLY_EXCEPTION,
        REPLY_EXC_LONG,
        REPLY_EXC_SID,
        REPLY_SHORT,
        REPLY_COUNT,
        REPLY_LONG,
        REPLY_ECHO,
        REPLY_ABORT
    } reply_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              item_valid = 1'b0;
    logic              item_stall;
    mrtu_pkg::item_t   item = '0;
    logic              result_valid;
    logic              result_stall = 1'b0;
    mrtu_pkg::result_t result;

    mrtu_pkg::item_t   pending_items[$];
    mrtu_pkg::result_t due_results[$];
    logic [7:0] reply_bytes[$];

    logic item_taken = 1'b0;
    logic calm = 1'b0;
    int   items_queued = 0;
    int   items_accepted = 0;
    int   random_count = 0;
    int   mismatches = 0;
    int   cycle_count = 0;
    int   holdoff_asked = 0;
    int   holdoff_served = 0;
    int   holdoff_left = 0;

    // master state as the predictor sees it
    logic [7:0]  m_func = '0;
    logic [7:0]  m_frame[8] = '{default: '0};
    logic [7:0]  m_head[8] = '{default: '0};
    int          m_count = 0;
    logic [15:0] m_crc = 16'hFFFF;
    logic [15:0] m_delayed = '0;

    // last valid request as the stimulus side knows it
    logic [7:0]  req_sid = 8'd1;
    logic [7:0]  req_func = mrtu_pkg::FUNC_READ;
    logic [15:0] req_addr = '0;
    logic [15:0] req_wval = '0;

    modbus_rtu_master_transaction_top #(
        .RX_MAX_LEN(RX_LIMIT)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .item(item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result(result)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [15:0] crc16_step(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        repeat (8)
        begin
            c = c[0] ? ((c >> 1) ^ mrtu_pkg::CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    task automatic clear_receiver();
        m_count = 0;
        m_crc = mrtu_pkg::CRC_INIT;
        m_delayed = '0;
    endtask

    task automatic push_status(input logic [3:0] st, input logic [15:0] val,
                               input logic [7:0] exc);
        mrtu_pkg::result_t r;
        r = '0;
        r.kind = mrtu_pkg::KIND_STATUS;
        r.last = 1'b1;
        r.status = st;
        r.read_value = val;
        r.exc_code = exc;
        due_results.push_back(r);
    endtask

    function automatic logic [3:0] check_response(output logic [15:0] val,
                                                  output logic [7:0] exc);
        val = '0;
        exc = '0;
        if (m_count < 4)
            return mrtu_pkg::ST_LENGTH;
        if ({m_delayed[7:0], m_delayed[15:8]} != m_crc)
            return mrtu_pkg::ST_CRC;
        if (m_head[1][7])
        begin
            if (m_count != 5 || m_head[1] != (m_func | mrtu_pkg::FUNC_EXC))
                return mrtu_pkg::ST_FUNCTION;
            if (m_head[0] != m_frame[0])
                return mrtu_pkg::ST_SLAVE;
            exc = m_head[2];
            return mrtu_pkg::ST_EXCEPTION;
        end
        if (m_head[0] != m_frame[0])
            return mrtu_pkg::ST_SLAVE;
        if (m_head[1] != m_func)
            return mrtu_pkg::ST_FUNCTION;
        if (m_func == mrtu_pkg::FUNC_READ)
        begin
            if (m_count != 7 || m_head[2] != mrtu_pkg::READ_BCOUNT)
                return mrtu_pkg::ST_LENGTH;
            val = {m_head[3], m_head[4]};
        end
        else if (m_func == mrtu_pkg::FUNC_WRITE)
        begin
            if (m_count != 8)
                return mrtu_pkg::ST_LENGTH;
            for (int i = 0; i < 8; i++)
            begin
                if (m_head[i] != m_frame[i])
                    return mrtu_pkg::ST_FUNCTION;
            end
        end
        return mrtu_pkg::ST_OK;
    endfunction

    task automatic master_step(input mrtu_pkg::item_t it);
        logic [15:0]       c;
        logic [15:0]       val;
        logic [7:0]        exc;
        logic [3:0]        st;
        mrtu_pkg::result_t r;
        case (it.cmd)
            mrtu_pkg::CMD_READ, mrtu_pkg::CMD_WRITE:
            begin
                if (it.slave_address == 8'd0 || it.slave_address > mrtu_pkg::SID_MAX)
                    push_status(mrtu_pkg::ST_PARAM, '0, '0);
                else
                begin
                    m_frame[0] = it.slave_address;
                    m_frame[1] = (it.cmd == mrtu_pkg::CMD_READ) ?
                                 mrtu_pkg::FUNC_READ : mrtu_pkg::FUNC_WRITE;
                    m_frame[2] = it.register_address[15:8];
                    m_frame[3] = it.register_address[7:0];
                    if (it.cmd == mrtu_pkg::CMD_READ)
                        {m_frame[4], m_frame[5]} = mrtu_pkg::READ_QTY;
                    else
                        {m_frame[4], m_frame[5]} = it.write_value;
                    c = mrtu_pkg::CRC_INIT;
                    for (int i = 0; i < 6; i++)
                        c = crc16_step(c, m_frame[i]);
                    m_frame[6] = c[7:0];
                    m_frame[7] = c[15:8];
                    m_func = m_frame[1];
                    clear_receiver();
                    for (int i = 0; i < 8; i++)
                    begin
                        r = '0;
                        r.kind = mrtu_pkg::KIND_FRAME;
                        r.tx_byte = m_frame[i];
                        r.last = (i == 7);
                        due_results.push_back(r);
                    end
                end
            end
            mrtu_pkg::CMD_RESP:
            begin
                if (m_count < RX_LIMIT)
                begin
                    if (m_count >= 2)
                        m_crc = crc16_step(m_crc, m_delayed[15:8]);
                    m_delayed = {m_delayed[7:0], it.rx_byte};
                    if (m_count < 8)
                        m_head[m_count[2:0]] = it.rx_byte;
                    m_count++;
                end
                if (it.rx_last)
                begin
                    st = check_response(val, exc);
                    clear_receiver();
                    push_status(st, val, exc);
                end
            end
            default:
            begin
                if (it.link_status != mrtu_pkg::LINK_OK)
                begin
                    case (it.link_status)
                        mrtu_pkg::LINK_PARAM: st = mrtu_pkg::ST_PARAM;
                        mrtu_pkg::LINK_RETRY: st = mrtu_pkg::ST_LENGTH;
                        mrtu_pkg::LINK_BUSY:  st = mrtu_pkg::ST_BUSY;
                        default:              st = mrtu_pkg::ST_TIMEOUT;
                    endcase
                    clear_receiver();
                    push_status(st, '0, '0);
                end
            end
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
    endtask

    task automatic check_result(input mrtu_pkg::result_t got);
        mrtu_pkg::result_t want;
        if (due_results.size() == 0)
        begin
            report_mismatch("result with nothing outstanding", 32'(got.status), 32'd0);
            return;
        end
        want = due_results.pop_front();
        if (got.kind != want.kind)
            report_mismatch("kind", 32'(got.kind), 32'(want.kind));
        if (got.tx_byte != want.tx_byte)
            report_mismatch("tx_byte", 32'(got.tx_byte), 32'(want.tx_byte));
        if (got.last != want.last)
            report_mismatch("last", 32'(got.last), 32'(want.last));
        if (got.status != want.status)
            report_mismatch("status", 32'(got.status), 32'(want.status));
        if (got.read_value != want.read_value)
            report_mismatch("read_value", 32'(got.read_value), 32'(want.read_value));
        if (got.exc_code != want.exc_code)
            report_mismatch("exc_code", 32'(got.exc_code), 32'(want.exc_code));
    endtask

    // acceptance, prediction and result checking
    always @(posedge clk)
    begin
        item_taken <= item_valid && !item_stall;
        if (rst_n)
        begin
            if (item_valid && !item_stall)
            begin
                master_step(item);
                items_accepted++;
            end
            if (result_valid && !result_stall)
                check_result(result);
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            item_valid <= 1'b0;
        else if (!item_valid || item_taken)
        begin
            if (pending_items.size() > 0 && (calm || $urandom_range(0, 99) >= 10))
            begin
                item <= pending_items.pop_front();
                item_valid <= 1'b1;
            end
            else
                item_valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (holdoff_left > 0)
        begin
            holdoff_left--;
            result_stall <= 1'b1;
        end
        else if (holdoff_served != holdoff_asked)
        begin
            holdoff_served++;
            holdoff_left = HOLDOFF_CYCLES - 1;
            result_stall <= 1'b1;
        end
        else
            result_stall <= !calm && ($urandom_range(0, 99) < 10);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic mrtu_pkg::item_t random_fields();
        mrtu_pkg::item_t it;
        it.cmd = 2'($urandom_range(0, 3));
        it.slave_address = 8'($urandom);
        it.register_address = 16'($urandom);
        it.write_value = 16'($urandom);
        it.rx_byte = 8'($urandom);
        it.rx_last = 1'($urandom);
        it.link_status = 3'($urandom_range(0, 4));
        return it;
    endfunction

    function automatic logic [7:0] nonzero_byte();
        return 8'($urandom_range(1, 255));
    endfunction

    task automatic queue_item(input mrtu_pkg::item_t it);
        pending_items.push_back(it);
        items_queued++;
        if (!(it.cmd == mrtu_pkg::CMD_LINK && it.link_status == mrtu_pkg::LINK_OK))
            random_count++;
    endtask

    task automatic queue_request(input logic [1:0] op, input logic [7:0] sid,
                                 input logic [15:0] addr, input logic [15:0] wval);
        mrtu_pkg::item_t it;
        it = random_fields();
        it.cmd = op;
        it.slave_address = sid;
        it.register_address = addr;
        it.write_value = wval;
        queue_item(it);
        if (sid != 8'd0 && sid <= mrtu_pkg::SID_MAX)
        begin
            req_sid = sid;
            req_func = (op == mrtu_pkg::CMD_READ) ? mrtu_pkg::FUNC_READ : mrtu_pkg::FUNC_WRITE;
            req_addr = addr;
            req_wval = wval;
        end
    endtask

    task automatic queue_link(input logic [2:0] code);
        mrtu_pkg::item_t it;
        it = random_fields();
        it.cmd = mrtu_pkg::CMD_LINK;
        it.link_status = code;
        queue_item(it);
    endtask

    task automatic queue_reply_bytes(input int count, input logic with_last);
        mrtu_pkg::item_t it;
        for (int i = 0; i < count; i++)
        begin
            it = random_fields();
            it.cmd = mrtu_pkg::CMD_RESP;
            it.rx_byte = reply_bytes[i];
            it.rx_last = with_last && (i == count - 1);
            queue_item(it);
        end
    endtask

    task automatic seal_reply();
        logic [15:0] c;
        c = mrtu_pkg::CRC_INIT;
        foreach (reply_bytes[i])
            c = crc16_step(c, reply_bytes[i]);
        reply_bytes.push_back(c[7:0]);
        reply_bytes.push_back(c[15:8]);
    endtask

    task automatic queue_reply(input reply_t shape);
        int cut;
        int pos;
        reply_bytes.delete();
        if (shape == REPLY_EXCEPTION || shape == REPLY_EXC_LONG || shape == REPLY_EXC_SID)
        begin
            reply_bytes.push_back(req_sid);
            reply_bytes.push_back(req_func | mrtu_pkg::FUNC_EXC);
            reply_bytes.push_back(8'($urandom));
            if (shape == REPLY_EXC_LONG)
                reply_bytes.push_back(8'($urandom));
            if (shape == REPLY_EXC_SID)
                reply_bytes[0] = reply_bytes[0] ^ nonzero_byte();
        end
        else
        begin
            reply_bytes.push_back(req_sid);
            reply_bytes.push_back(req_func);
            if (req_func == mrtu_pkg::FUNC_READ)
            begin
                reply_bytes.push_back(mrtu_pkg::READ_BCOUNT);
                reply_bytes.push_back(8'($urandom));
                reply_bytes.push_back(8'($urandom));
            end
            else
            begin
                reply_bytes.push_back(req_addr[15:8]);
                reply_bytes.push_back(req_addr[7:0]);
                reply_bytes.push_back(req_wval[15:8]);
                reply_bytes.push_back(req_wval[7:0]);
            end
            case (shape)
                REPLY_SID:  reply_bytes[0] = reply_bytes[0] ^ nonzero_byte();
                REPLY_FUNC: reply_bytes[1] = reply_bytes[1] ^ 8'($urandom_range(1, 127));
                REPLY_SHORT:
                begin
                    cut = $urandom_range(0, 1);
                    while (reply_bytes.size() > cut)
                        void'(reply_bytes.pop_back());
                end
                REPLY_COUNT:
                begin
                    if (req_func == mrtu_pkg::FUNC_READ)
                        reply_bytes[2] = reply_bytes[2] ^ nonzero_byte();
                    else
                        void'(reply_bytes.pop_back());
                end
                REPLY_LONG: reply_bytes.push_back(8'($urandom));
                REPLY_ECHO:
                begin
                    pos = 2 + $urandom_range(0, 3);
                    reply_bytes[pos] = reply_bytes[pos] ^ nonzero_byte();
                end
                default: ;
            endcase
        end
        seal_reply();
        if (shape == REPLY_CRC)
        begin
            pos = $urandom_range(0, reply_bytes.size() - 1);
            reply_bytes[pos] = reply_bytes[pos] ^ (8'd1 << $urandom_range(0, 7));
        end
        if (shape == REPLY_ABORT)
        begin
            queue_reply_bytes($urandom_range(1, reply_bytes.size() - 1), 1'b0);
            queue_link(3'($urandom_range(1, 4)));
        end
        else
            queue_reply_bytes(reply_bytes.size(), 1'b1);
    endtask

    task automatic queue_random_sequence();
        int pick;
        int count;
        mrtu_pkg::item_t it;
        pick = $urandom_range(0, 99);
        if (pick < 60)
        begin
            queue_request($urandom_range(0, 1) ? mrtu_pkg::CMD_WRITE : mrtu_pkg::CMD_READ,
                          8'($urandom_range(1, mrtu_pkg::SID_MAX)),
                          16'($urandom), 16'($urandom));
            if ($urandom_range(0, 1))
                queue_reply(REPLY_GOOD);
            else
                queue_reply(reply_t'($urandom_range(0, REPLY_ABORT)));
        end
        else if (pick < 68)
            queue_request($urandom_range(0, 1) ? mrtu_pkg::CMD_WRITE : mrtu_pkg::CMD_READ,
                          ($urandom_range(0, 8) == 0) ? 8'd0 : 8'($urandom_range(248, 255)),
                          16'($urandom), 16'($urandom));
        else if (pick < 84)
            queue_link(3'($urandom_range(0, 4)));
        else
        begin
            count = $urandom_range(1, 6);
            for (int i = 0; i < count; i++)
            begin
                it = random_fields();
                it.cmd = mrtu_pkg::CMD_RESP;
                it.rx_last = ($urandom_range(0, 3) == 0);
                queue_item(it);
            end
        end
    endtask

    task automatic queue_overlong_reply();
        queue_request(mrtu_pkg::CMD_READ, 8'($urandom_range(1, mrtu_pkg::SID_MAX)),
                      16'($urandom), 16'($urandom));
        reply_bytes.delete();
        reply_bytes.push_back(req_sid);
        reply_bytes.push_back(req_func);
        repeat (RX_LIMIT - 4)
            reply_bytes.push_back(8'($urandom));
        seal_reply();
        repeat (3)
            reply_bytes.push_back(8'($urandom));
        queue_reply_bytes(reply_bytes.size(), 1'b1);
    endtask

    task automatic wait_drained();
        while (items_accepted != items_queued || due_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    initial
    begin
        repeat (10)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes, every command, param ids, every link event, lone last byte
        queue_request(mrtu_pkg::CMD_READ, 8'd1, 16'h0000, 16'h0000);
        queue_reply(REPLY_GOOD);
        queue_request(mrtu_pkg::CMD_WRITE, mrtu_pkg::SID_MAX, 16'hFFFF, 16'hFFFF);
        queue_reply(REPLY_EXCEPTION);
        queue_request(mrtu_pkg::CMD_WRITE, 8'd0, 16'h1234, 16'h5678);
        queue_request(mrtu_pkg::CMD_READ, 8'd248, 16'hFFFF, 16'h0000);
        queue_request(mrtu_pkg::CMD_WRITE, 8'd255, 16'h0000, 16'hFFFF);
        queue_link(mrtu_pkg::LINK_OK);
        queue_link(mrtu_pkg::LINK_TIMEOUT);
        queue_link(mrtu_pkg::LINK_PARAM);
        queue_link(mrtu_pkg::LINK_RETRY);
        queue_link(mrtu_pkg::LINK_BUSY);
        reply_bytes.delete();
        reply_bytes.push_back(8'hFF);
        queue_reply_bytes(1, 1'b1);
        wait_drained();

        // no idling on either side
        calm = 1'b1;
        while (random_count < 120)
            queue_random_sequence();
        wait_drained();
        calm = 1'b0;

        while (random_count < 190)
            queue_random_sequence();
        wait_drained();

        // receiver holds off while requests keep coming
        holdoff_asked++;
        repeat (30)
            queue_request($urandom_range(0, 1) ? mrtu_pkg::CMD_WRITE : mrtu_pkg::CMD_READ,
                          8'($urandom_range(1, mrtu_pkg::SID_MAX)),
                          16'($urandom), 16'($urandom));
        wait_drained();

        queue_overlong_reply();
        while (random_count < 480)
            queue_random_sequence();
        wait_drained();

        if (due_results.size() != 0)
            report_mismatch("results never delivered", 32'(due_results.size()), 32'd0);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[modbus_rtu_master_transaction_top.f]
hdl/mrtu_pkg.sv
hdl/mrtu_queue.sv
hdl/mrtu_front.sv
hdl/mrtu_back.sv
hdl/modbus_rtu_master_transaction_top.sv
tb/sv/testbench.sv
